// File: src/cprf_pkg.sv
// ----------------------------------------------------------------------------
// cprf_pkg: shared types for the segment repeat filter
// Sizes, channel payload types, status codes and float compare helpers.
// ----------------------------------------------------------------------------
package cprf_pkg;

  localparam int HIST_DEPTH = 64;
  localparam int IDX_W      = $clog2(HIST_DEPTH);
  localparam int CNT_W      = $clog2(HIST_DEPTH + 1);
  localparam int LEN_W      = 7;
  localparam int WORD_W     = 32;

  typedef logic [WORD_W-1:0] word_t;

  // one segment, two points
  typedef struct packed {
    word_t first_x;
    word_t first_y;
    word_t second_x;
    word_t second_y;
  } seg_t;

  typedef enum logic [1:0] {
    STATUS_NEW    = 2'd0,
    STATUS_REPEAT = 2'd1,
    STATUS_UNCONF = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DONE
  } ctrl_state_t;

  localparam logic OP_CHECK = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // probe travelling down the cell chain
  typedef struct packed {
    logic vld;
    logic hit;
    seg_t seg;
  } probe_t;

  // broadcast control from the controller to every cell
  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    seg_t             wr_seg;
    logic [CNT_W-1:0] vcount;
  } cell_ctl_t;

  function automatic logic is_nan(input word_t w);
    return (w[30:23] == 8'hFF) && (w[22:0] != 23'd0);
  endfunction

  // float equality: signed zeros equal, nan never equal
  function automatic logic float_eq(input word_t a, input word_t b);
    logic r;
    if (is_nan(a) || is_nan(b)) begin
      r = 1'b0;
    end else if (a == b) begin
      r = 1'b1;
    end else begin
      r = ((a | b) & 32'h7FFF_FFFF) == 32'd0;
    end
    return r;
  endfunction

  function automatic logic seg_eq(input seg_t a, input seg_t b);
    return float_eq(a.first_x, b.first_x) && float_eq(a.first_y, b.first_y) &&
           float_eq(a.second_x, b.second_x) && float_eq(a.second_y, b.second_y);
  endfunction

endpackage

// File: src/cprf_if.sv
// ----------------------------------------------------------------------------
// cprf_if: channel interfaces of the segment repeat filter
// Segment request channel, status result channel and length config channel.
// ----------------------------------------------------------------------------
interface cprf_in_if;
  import cprf_pkg::*;
  logic  valid;
  logic  ready;
  logic  operation;
  word_t first_x;
  word_t first_y;
  word_t second_x;
  word_t second_y;
  modport source(output valid, operation, first_x, first_y, second_x, second_y,
                 input ready);
  modport sink(input valid, operation, first_x, first_y, second_x, second_y,
               output ready);
endinterface

interface cprf_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  modport source(output valid, status, input ready);
  modport sink(input valid, status, output ready);
endinterface

interface cprf_cfg_if;
  import cprf_pkg::*;
  logic             valid;
  logic             ready;
  logic [LEN_W-1:0] history_length;
  modport source(output valid, history_length, input ready);
  modport sink(input valid, history_length, output ready);
endinterface

// File: src/cprf_cell.sv
// ----------------------------------------------------------------------------
// cprf_cell: one history entry of the chain
// Holds one stored segment, compares it with the passing probe and hands the
// probe with its accumulated hit flag to the next cell.
// ----------------------------------------------------------------------------
module cprf_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [cprf_pkg::IDX_W-1:0]  idx,
  input  cprf_pkg::cell_ctl_t         ctl,
  input  cprf_pkg::probe_t            probe_in,
  output cprf_pkg::probe_t            probe_out
);
  import cprf_pkg::*;

  seg_t   entry_r;
  probe_t probe_r;
  probe_t probe_nxt;
  logic   active;
  logic   match;

  // only entries below the fill count take part
  assign active = {1'b0, idx} < ctl.vcount;
  assign match  = probe_in.vld && active && seg_eq(entry_r, probe_in.seg);

  always_comb begin
    probe_nxt     = probe_in;
    probe_nxt.hit = probe_in.hit | match;
  end

  // stored entry, written by broadcast address
  always_ff @(posedge clk) begin
    if (ctl.wr_en && (ctl.wr_idx == idx)) begin
      entry_r <= ctl.wr_seg;
    end
  end

  // probe valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_r.vld <= 1'b0;
    end else begin
      probe_r.vld <= probe_nxt.vld;
    end
  end

  // probe payload
  always_ff @(posedge clk) begin
    probe_r.hit <= probe_nxt.hit;
    probe_r.seg <= probe_nxt.seg;
  end

  assign probe_out = probe_r;

endmodule

// File: src/cprf_ctrl.sv
// ----------------------------------------------------------------------------
// cprf_ctrl: request sequencer of the segment repeat filter
// Accepts a request, launches a probe into the cell chain, records the
// segment when the probe leaves the chain without a hit and drives results.
// ----------------------------------------------------------------------------
module cprf_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  cprf_in_if.sink                     in_chan,
  cprf_out_if.source                  out_chan,
  input  logic [cprf_pkg::LEN_W-1:0]  history_length,
  input  cprf_pkg::probe_t            tail,
  output cprf_pkg::probe_t            head,
  output cprf_pkg::cell_ctl_t         ctl
);
  import cprf_pkg::*;

  ctrl_state_t      state_r, state_nxt;
  logic [CNT_W-1:0] vc_r, vc_nxt;
  logic [IDX_W-1:0] wp_r, wp_nxt;
  probe_t           head_r, head_nxt;
  status_t          status_r, status_nxt;
  logic             out_valid_r, out_valid_nxt;
  status_t          out_status_r, out_status_nxt;

  logic [CNT_W-1:0] len;
  logic [CNT_W-1:0] vc_eff;
  logic [IDX_W-1:0] wp_eff;
  logic [CNT_W-1:0] wp_inc;
  logic             in_ready_c;
  logic             wr_en_c;

  // effective length, capped at the depth
  assign len = (history_length > LEN_W'(HIST_DEPTH)) ? CNT_W'(HIST_DEPTH)
                                                     : CNT_W'(history_length);

  // clear request and length trimming
  always_comb begin
    if (in_chan.operation == OP_CLEAR) begin
      vc_eff = '0;
      wp_eff = '0;
    end else begin
      vc_eff = (vc_r > len) ? len : vc_r;
      wp_eff = ({1'b0, wp_r} >= len) ? '0 : wp_r;
    end
  end

  assign wp_inc = {1'b0, wp_r} + CNT_W'(1);

  // next state and outputs
  always_comb begin
    state_nxt      = state_r;
    vc_nxt         = vc_r;
    wp_nxt         = wp_r;
    head_nxt       = head_r;
    head_nxt.vld   = 1'b0;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    out_status_nxt = out_status_r;
    in_ready_c     = 1'b0;
    wr_en_c        = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready_c = 1'b1;
        if (in_chan.valid) begin
          vc_nxt = vc_eff;
          wp_nxt = wp_eff;
          if (len == '0) begin
            status_nxt = STATUS_UNCONF;
            state_nxt  = ST_DONE;
          end else begin
            head_nxt.vld = 1'b1;
            head_nxt.hit = 1'b0;
            head_nxt.seg = '{first_x:  in_chan.first_x,
                             first_y:  in_chan.first_y,
                             second_x: in_chan.second_x,
                             second_y: in_chan.second_y};
            state_nxt    = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        if (tail.vld) begin
          state_nxt = ST_DONE;
          if (tail.hit) begin
            status_nxt = STATUS_REPEAT;
          end else begin
            status_nxt = STATUS_NEW;
            wr_en_c    = 1'b1;
            wp_nxt     = (wp_inc >= len) ? '0 : wp_inc[IDX_W-1:0];
            if (vc_r < len) begin
              vc_nxt = vc_r + CNT_W'(1);
            end
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      vc_r        <= '0;
      wp_r        <= '0;
      head_r.vld  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vc_r        <= vc_nxt;
      wp_r        <= wp_nxt;
      head_r.vld  <= head_nxt.vld;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    head_r.hit   <= head_nxt.hit;
    head_r.seg   <= head_nxt.seg;
    status_r     <= status_nxt;
    out_status_r <= out_status_nxt;
  end

  // broadcast to the cells
  assign ctl.wr_en  = wr_en_c;
  assign ctl.wr_idx = wp_r;
  assign ctl.wr_seg = tail.seg;
  assign ctl.vcount = vc_r;

  assign head            = head_r;
  assign in_chan.ready   = in_ready_c;
  assign out_chan.valid  = out_valid_r;
  assign out_chan.status = out_status_r;

endmodule

// File: src/coordinate_pair_repeat_filter.sv
// ----------------------------------------------------------------------------
// coordinate_pair_repeat_filter: segment repeat filter, top level
// Each request carries one segment as two points in IEEE single bit patterns.
// The segment is searched in a history of recent segments; a match returns
// repeat, otherwise the segment replaces the oldest entry and returns new.
// Channels: in_chan takes requests (operation 1 empties the history first),
// out_chan returns one status per request, cfg_chan writes history_length
// (0 means unconfigured, above the depth of 64 acts as 64); write it only
// while no request is outstanding.
// Search: a probe walks a chain of 64 compare cells, one cell per cycle; when
// the history is unconfigured the result is given without a search. One
// request is in flight at a time: the next is taken at the earliest in the
// cycle after the result is loaded. The length of the chain sets how long a
// search takes.
// Reset empties the history and clears history_length. A stalled receiver
// holds the result in the output register; the next request can still be
// taken and searched, and its result waits until the register is free.
// ----------------------------------------------------------------------------
module coordinate_pair_repeat_filter (
  input  logic        clk,
  input  logic        rst_n,
  cprf_in_if.sink     in_chan,
  cprf_out_if.source  out_chan,
  cprf_cfg_if.sink    cfg_chan
);
  import cprf_pkg::*;

  logic [LEN_W-1:0] hist_len_r;
  probe_t           link [HIST_DEPTH+1];
  cell_ctl_t        ctl;

  // length register, always ready
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_len_r <= '0;
    end else if (cfg_chan.valid) begin
      hist_len_r <= cfg_chan.history_length;
    end
  end

  // sequencer
  cprf_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_chan        (in_chan),
    .out_chan       (out_chan),
    .history_length (hist_len_r),
    .tail           (link[HIST_DEPTH]),
    .head           (link[0]),
    .ctl            (ctl)
  );

  // chain of compare cells
  for (genvar i = 0; i < HIST_DEPTH; i++) begin : g_cell
    cprf_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .idx       (IDX_W'(i)),
      .ctl       (ctl),
      .probe_in  (link[i]),
      .probe_out (link[i+1])
    );
  end

endmodule

// File: src/cprf_chk.sv
// ----------------------------------------------------------------------------
// cprf_chk: port checker for the segment repeat filter
// Watches the request and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module cprf_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] status
);
  import cprf_pkg::*;

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status))
    else $error("stalled result changed");

  // only defined status codes
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (status == STATUS_NEW) || (status == STATUS_REPEAT) ||
                  (status == STATUS_UNCONF))
    else $error("undefined status code");

  // one request at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_acc)
    else $error("request taken while busy");

  // no result in the cycle right after a request with an empty output
  a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !out_valid |=> !out_valid)
    else $error("result appeared too early");

endmodule

bind coordinate_pair_repeat_filter cprf_chk u_cprf_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .status    (out_chan.status)
);
